// ===== sv/rss_pkg.sv =====
// Shared types and constants for the rate slot spreader.
// No dependencies; imported by rss_div, rate_slot_spreader and rss_chk.
package rss_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_SLOTS_DEF = 32;
  // stride register width; holds any stride reached with up to 64 slots
  localparam int STRIDE_W      = 8;
  localparam int CFG_IDX_W     = 1;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_INF   = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [31:0]       desired;
    logic              desired_infinite;
    logic [5:0]        displacement;
  } rss_in_t;

  typedef struct packed {
    logic [5:0]        slot_index;
    logic [31:0]       slot_amount;
    logic [6:0]        slots_used;
    logic              last;
    logic              status;
  } rss_out_t;

  // pass and division operations of the sequencer
  typedef enum logic [3:0] {
    OP_DIVB, OP_DIVS, OP_DIVK, OP_INIT, OP_MIN, OP_INC, OP_SUM, OP_CLR,
    OP_FIND, OP_HCLR, OP_HCNT, OP_LIM, OP_APPLY, OP_TAKE, OP_OUT
  } rss_op_t;

endpackage

// ===== sv/rss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/rss_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on rss_pkg for the data width.
module rss_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rss_pkg::DATA_W-1:0] dividend,
  input  logic [rss_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [rss_pkg::DATA_W-1:0] quotient,
  output logic [rss_pkg::DATA_W-1:0] remainder
);
  import rss_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] r_r;
  logic [DATA_W-1:0] d_r;
  logic [DATA_W:0]   trial;
  logic              fits;

  assign trial = {r_r, q_r[DATA_W-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        r_r    <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        r_r <= fits ? DATA_W'(trial - {1'b0, d_r}) : trial[DATA_W-1:0];
        q_r <= {q_r[DATA_W-2:0], fits};
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = r_r;

endmodule

// ===== sv/rate_slot_spreader.sv =====
// Rate slot spreader top level: pool and share RAMs, pass sequencer.
// Depends on rss_pkg, rss_ram and rss_div.
//
// Start an item with start while busy is low. Results come one per strobe of
// out_valid and cannot be held off; last marks the final one. Simple cases
// (ack of a zero rate, infinite or zero share, infinite pool, share on an
// empty pool) answer in the cycle after start. All other work runs as passes
// over the pool RAM, each slot visit going through read, execute and write
// back, and every division runs on the shared bit-serial divider. A rebuild
// of a finite rate takes one division and a fill pass, and for a remainder one
// more division plus a minimum search and a spreading pass per round. A share
// takes a sum pass and a clearing pass, then per walk round a search for the
// first nonzero slot and a stride pass; rounds at stride one first count
// visits over N-1 strides (N = slots), then bound the bulk step with one
// division per visited slot, and apply whole cycles of strides at once, which
// bounds the rounds regardless of the amount. Output is one result per slot
// visit of the final output pass.
module rate_slot_spreader #(
  parameter int MAX_SLOTS = rss_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  rss_pkg::rss_in_t              in_data,
  output logic                          out_valid,
  output rss_pkg::rss_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [rss_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rss_pkg::DATA_W-1:0]    cfg_wdata
);
  import rss_pkg::*;

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int HW = CW;
  localparam int TW = 2 * CW;
  localparam int SW = STRIDE_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_EX   = 7'b0000100,
    S_WB   = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_NEXT = 7'b0100000,
    S_MOD  = 7'b1000000
  } state_t;

  state_t               state_r;
  rss_op_t              op_r;
  logic [DATA_W-1:0]    total_rate_r;
  logic                 rate_inf_r;
  logic [CW-1:0]        count_r;
  logic                 unlim_r;
  logic [SW-1:0]        idx_r, i0_r, midx_r, step_r, s_r;
  logic                 found_r;
  logic [CW-1:0]        p_r;
  logic [TW-1:0]        tot_r;
  logic [DATA_W-1:0]    base_r, rem_r, k_r, prod_r, ktot_r, min_r;
  logic [DATA_W+CW-1:0] sum_r;
  logic                 out_valid_r;
  rss_out_t             out_r;

  // divider
  logic              div_start_r;
  logic [DATA_W-1:0] div_a_r, div_b_r;
  logic              div_done;
  logic [DATA_W-1:0] div_q, div_rm;

  // memories: pool entry holds {visit count, units}
  logic                 pool_we, share_we;
  logic [HW+DATA_W-1:0] pool_wdata, pool_rd;
  logic [DATA_W-1:0]    share_wdata, share_rd;
  logic [DATA_W-1:0]    rd_pool;
  logic [HW-1:0]        rd_h;

  logic [SW:0]          cnt_ext, inc_sum, step_sum, s_sum;
  logic [CW-1:0]        cnt_new, len;
  logic [DATA_W-1:0]    take_rem;

  rss_ram #(.WIDTH(HW + DATA_W), .DEPTH(MAX_SLOTS)) u_pool (
    .clk(clk), .we(pool_we), .waddr(idx_r[AW-1:0]), .wdata(pool_wdata),
    .raddr(idx_r[AW-1:0]), .rdata(pool_rd)
  );

  rss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SLOTS)) u_share (
    .clk(clk), .we(share_we), .waddr(idx_r[AW-1:0]), .wdata(share_wdata),
    .raddr(idx_r[AW-1:0]), .rdata(share_rd)
  );

  rss_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .dividend(div_a_r),
    .divisor(div_b_r), .done(div_done), .quotient(div_q), .remainder(div_rm)
  );

  assign rd_pool  = pool_rd[DATA_W-1:0];
  assign rd_h     = pool_rd[DATA_W +: HW];
  assign cnt_ext  = (SW+1)'(count_r);
  assign inc_sum  = {1'b0, idx_r} + 1'b1;
  assign step_sum = {1'b0, idx_r} + {1'b0, step_r};
  assign s_sum    = {1'b0, idx_r} + {1'b0, s_r};
  assign cnt_new  = (total_rate_r < DATA_W'(MAX_SLOTS)) ? CW'(total_rate_r)
                                                         : CW'(MAX_SLOTS);
  assign len      = (count_r > CW'(1)) ? count_r - 1'b1 : CW'(1);
  assign take_rem = (rd_pool != '0) ? rem_r - 1'b1 : rem_r;

  // Writes happen in the write-back state; the next read of any slot is
  // issued in a later cycle, so no forwarding is needed.
  always_comb begin
    pool_we     = 1'b0;
    pool_wdata  = pool_rd;
    share_we    = 1'b0;
    share_wdata = share_rd;
    if (state_r == S_WB) begin
      unique case (op_r)
        OP_INIT: begin
          pool_we    = 1'b1;
          pool_wdata = {HW'(0), base_r};
        end
        OP_INC: begin
          pool_we    = 1'b1;
          pool_wdata = {rd_h, rd_pool + 1'b1};
        end
        OP_CLR: begin
          share_we    = 1'b1;
          share_wdata = '0;
        end
        OP_HCLR: begin
          pool_we    = 1'b1;
          pool_wdata = {HW'(0), rd_pool};
        end
        OP_HCNT: begin
          pool_we    = rd_pool != '0;
          pool_wdata = {rd_h + 1'b1, rd_pool};
        end
        OP_APPLY: begin
          pool_we     = 1'b1;
          pool_wdata  = {rd_h, rd_pool - prod_r};
          share_we    = 1'b1;
          share_wdata = share_rd + prod_r;
        end
        OP_TAKE: begin
          pool_we     = rd_pool != '0;
          pool_wdata  = {rd_h, rd_pool - 1'b1};
          share_we    = rd_pool != '0;
          share_wdata = share_rd + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  function automatic rss_out_t mk_out(logic [5:0] idx, logic [31:0] amt,
                                      logic [6:0] used, logic lst, logic st);
    rss_out_t o;
    o.slot_index  = idx;
    o.slot_amount = amt;
    o.slots_used  = used;
    o.last        = lst;
    o.status      = st;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      div_start_r  <= 1'b0;
      count_r      <= '0;
      unlim_r      <= 1'b0;
      total_rate_r <= '0;
      rate_inf_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_TOTAL_RATE: total_rate_r <= cfg_wdata;
          CFG_RATE_INF:   rate_inf_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (!in_data.mode) begin
              unlim_r <= 1'b0;
              count_r <= '0;
              if (rate_inf_r) begin
                count_r <= CW'(1);
                unlim_r <= 1'b1;
                base_r  <= ALL_ONES;
                rem_r   <= '0;
                op_r    <= OP_INIT;
                idx_r   <= '0;
                state_r <= S_RD;
              end else if (total_rate_r == '0) begin
                out_valid_r <= 1'b1;
                out_r       <= mk_out('0, '0, '0, 1'b1, 1'b0);
              end else begin
                count_r     <= cnt_new;
                div_a_r     <= total_rate_r;
                div_b_r     <= DATA_W'(cnt_new);
                div_start_r <= 1'b1;
                op_r        <= OP_DIVB;
                state_r     <= S_DIV;
              end
            end else if (in_data.desired_infinite) begin
              out_valid_r <= 1'b1;
              out_r       <= mk_out('0, ALL_ONES, 7'd1, 1'b1, 1'b0);
            end else if (in_data.desired == '0) begin
              out_valid_r <= 1'b1;
              out_r       <= mk_out('0, '0, '0, 1'b1, 1'b0);
            end else if (unlim_r) begin
              out_valid_r <= 1'b1;
              out_r       <= mk_out('0, in_data.desired, 7'd1, 1'b1, 1'b0);
            end else if (count_r == '0) begin
              out_valid_r <= 1'b1;
              out_r       <= mk_out('0, '0, '0, 1'b1, 1'b1);
            end else begin
              rem_r   <= in_data.desired;
              step_r  <= (in_data.displacement == '0) ? SW'(1)
                                                      : SW'(in_data.displacement);
              sum_r   <= '0;
              op_r    <= OP_SUM;
              idx_r   <= '0;
              state_r <= S_RD;
            end
          end
        end

        S_RD: state_r <= S_EX;

        S_EX: begin
          prod_r <= k_r * DATA_W'(rd_h);
          if (op_r == OP_LIM && rd_h != '0) begin
            div_a_r     <= rd_pool - 1'b1;
            div_b_r     <= DATA_W'(rd_h);
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end else begin
            state_r <= S_WB;
          end
        end

        S_DIV: begin
          if (div_done) begin
            unique case (op_r)
              OP_DIVB: begin
                base_r  <= div_q;
                rem_r   <= div_rm;
                op_r    <= OP_INIT;
                idx_r   <= '0;
                state_r <= S_RD;
              end
              OP_DIVS: begin
                step_r  <= SW'(div_q);
                op_r    <= OP_MIN;
                idx_r   <= '0;
                state_r <= S_RD;
              end
              OP_DIVK: begin
                k_r     <= div_q;
                op_r    <= OP_LIM;
                idx_r   <= '0;
                state_r <= S_RD;
              end
              OP_LIM: begin
                if (div_q < k_r) begin
                  k_r <= div_q;
                end
                state_r <= S_WB;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end

        S_WB: begin
          state_r <= S_RD;
          idx_r   <= inc_sum[SW-1:0];
          if (inc_sum >= cnt_ext) begin
            state_r <= S_NEXT;
          end
          unique case (op_r)
            OP_MIN: begin
              if (idx_r == '0 || rd_pool < min_r) begin
                min_r  <= rd_pool;
                midx_r <= idx_r;
              end
            end
            OP_SUM: sum_r <= sum_r + (DATA_W+CW)'(rd_pool);
            OP_OUT: begin
              out_valid_r <= 1'b1;
              out_r       <= mk_out(6'(idx_r), share_rd, 7'(count_r),
                                    inc_sum == cnt_ext, 1'b0);
            end
            OP_INC: begin
              rem_r <= rem_r - 1'b1;
              idx_r <= step_sum[SW-1:0];
              state_r <= (step_sum >= cnt_ext || rem_r == DATA_W'(1)) ? S_NEXT
                                                                        : S_RD;
            end
            OP_FIND: begin
              if (rd_pool != '0) begin
                found_r <= 1'b1;
                i0_r    <= idx_r;
                state_r <= S_NEXT;
              end
            end
            OP_HCNT: begin
              if (rd_pool != '0) begin
                tot_r <= tot_r + 1'b1;
              end
              idx_r   <= s_sum[SW-1:0];
              state_r <= (s_sum >= cnt_ext) ? S_NEXT : S_RD;
            end
            OP_TAKE: begin
              rem_r   <= take_rem;
              idx_r   <= step_sum[SW-1:0];
              state_r <= (step_sum >= cnt_ext || take_rem == '0) ? S_NEXT : S_RD;
            end
            default: begin
            end
          endcase
        end

        S_NEXT: begin
          state_r <= S_RD;
          idx_r   <= '0;
          unique case (op_r)
            OP_INIT: begin
              if (rem_r == '0) begin
                out_valid_r <= 1'b1;
                out_r       <= mk_out('0, '0, 7'(count_r), 1'b1, 1'b0);
                state_r     <= S_IDLE;
              end else begin
                div_a_r     <= DATA_W'(count_r);
                div_b_r     <= rem_r;
                div_start_r <= 1'b1;
                op_r        <= OP_DIVS;
                state_r     <= S_DIV;
              end
            end
            OP_MIN: begin
              op_r  <= OP_INC;
              idx_r <= midx_r;
            end
            OP_INC: begin
              step_r <= step_r + 1'b1;
              if (rem_r == '0) begin
                out_valid_r <= 1'b1;
                out_r       <= mk_out('0, '0, 7'(count_r), 1'b1, 1'b0);
                state_r     <= S_IDLE;
              end else begin
                op_r <= OP_MIN;
              end
            end
            OP_SUM: begin
              if (sum_r < (DATA_W+CW)'(rem_r)) begin
                out_valid_r <= 1'b1;
                out_r       <= mk_out('0, '0, '0, 1'b1, 1'b1);
                state_r     <= S_IDLE;
              end else begin
                op_r <= OP_CLR;
              end
            end
            OP_CLR: begin
              found_r <= 1'b0;
              op_r    <= OP_FIND;
            end
            OP_FIND: begin
              if (!found_r) begin
                op_r <= OP_OUT;
              end else if (step_r == SW'(1)) begin
                tot_r <= '0;
                p_r   <= '0;
                s_r   <= SW'(1);
                op_r  <= OP_HCLR;
              end else begin
                op_r  <= OP_TAKE;
                idx_r <= i0_r;
              end
            end
            OP_HCLR: begin
              op_r  <= OP_HCNT;
              idx_r <= i0_r;
            end
            OP_HCNT: begin
              p_r   <= p_r + 1'b1;
              s_r   <= ((s_r + 1'b1) >= SW'(count_r)) ? SW'(1) : s_r + 1'b1;
              idx_r <= i0_r;
              if (p_r + 1'b1 != len) begin
                op_r <= OP_HCNT;
              end else if (tot_r == '0) begin
                op_r <= OP_TAKE;
              end else begin
                div_a_r     <= rem_r - 1'b1;
                div_b_r     <= DATA_W'(tot_r);
                div_start_r <= 1'b1;
                op_r        <= OP_DIVK;
                state_r     <= S_DIV;
              end
            end
            OP_LIM: begin
              if (k_r == '0) begin
                op_r  <= OP_TAKE;
                idx_r <= i0_r;
              end else begin
                ktot_r <= k_r * DATA_W'(tot_r);
                op_r   <= OP_APPLY;
              end
            end
            OP_APPLY: begin
              rem_r <= rem_r - ktot_r;
              op_r  <= OP_TAKE;
              idx_r <= i0_r;
            end
            OP_TAKE: begin
              step_r  <= step_r + 1'b1;
              state_r <= S_MOD;
            end
            default: state_r <= S_IDLE;
          endcase
        end

        // reduce the stride modulo the slot count, zero becomes one
        S_MOD: begin
          if (step_r >= SW'(count_r)) begin
            step_r <= step_r - SW'(count_r);
          end else begin
            if (step_r == '0) begin
              step_r <= SW'(1);
            end
            idx_r   <= '0;
            found_r <= 1'b0;
            op_r    <= (rem_r == '0) ? OP_OUT : OP_FIND;
            state_r <= S_RD;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sv/rss_chk.sv =====
// Port-level assertions for the rate slot spreader, bound to the top level.
// Depends on rss_pkg and rate_slot_spreader.
module rss_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input rss_pkg::rss_out_t out_data
);
  import rss_pkg::*;

  // a rejected share is a single empty result
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      out_data.last && out_data.slot_amount == '0 && out_data.slots_used == '0)
    else $error("status result not a single empty result");

  // more results pending means the block is still working
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> busy)
    else $error("non-final result while idle");

  // share results come in slot order, each one slot visit after the last
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.slot_index != '0 |->
      $past(out_valid, 3) && ($past(out_data.slot_index, 3) + 6'd1 ==
                              out_data.slot_index))
    else $error("slot results out of order");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.slot_index != '0 |->
      7'(out_data.slot_index) < out_data.slots_used)
    else $error("slot index beyond slots used");

endmodule

bind rate_slot_spreader rss_chk u_rss_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);
